// File: hdl/ps2_scan_code_key_decoder_assert.svh
// Assertion macros shared by the scan-code decoder modules.
`ifndef PS2_SCAN_CODE_KEY_DECODER_ASSERT_SVH
`define PS2_SCAN_CODE_KEY_DECODER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PS2KD_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ps2kd: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PS2KD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ps2kd: next-cycle check failed");

`endif

// File: hdl/ps2kd_pkg.sv
// Types, constants and make-code lookup for the scan-code decoder.
`timescale 1ns / 1ps

package ps2kd_pkg;

    localparam int NUM_KEYS = 88;
    localparam int KEY_W    = $clog2(NUM_KEYS);

    // Result kinds
    typedef enum logic [1:0] {
        KIND_KEY     = 2'd0,
        KIND_TX      = 2'd1,
        KIND_UNKNOWN = 2'd2,
        KIND_REINIT  = 2'd3
    } kind_t;

    // Key numbers with a special action
    localparam logic [KEY_W-1:0] KEY_SELFTEST = KEY_W'(0);
    localparam logic [KEY_W-1:0] KEY_BREAK    = KEY_W'(1);
    localparam logic [KEY_W-1:0] KEY_ACK      = KEY_W'(2);
    localparam logic [KEY_W-1:0] KEY_CAPS     = KEY_W'(46);
    localparam logic [KEY_W-1:0] KEY_LSHIFT   = KEY_W'(47);
    localparam logic [KEY_W-1:0] KEY_RSHIFT   = KEY_W'(50);
    localparam logic [KEY_W-1:0] KEY_SCROLL   = KEY_W'(65);
    localparam logic [KEY_W-1:0] KEY_NUM      = KEY_W'(68);

    // Lock bits (also the LED mask layout)
    localparam logic [2:0] LED_SCROLL = 3'b001;
    localparam logic [2:0] LED_NUM    = 3'b010;
    localparam logic [2:0] LED_CAPS   = 3'b100;

    // Hold bits
    localparam logic [4:0] HOLD_LSHIFT = 5'b00001;
    localparam logic [4:0] HOLD_RSHIFT = 5'b00010;
    localparam logic [4:0] HOLD_CAPS   = 5'b00100;
    localparam logic [4:0] HOLD_SCROLL = 5'b01000;
    localparam logic [4:0] HOLD_NUM    = 5'b10000;

    localparam logic [7:0] CODE_LED_CMD = 8'hED;
    localparam logic [7:0] CASE_OFFSET  = 8'd85;

    // Make codes, indexed by key number
    localparam logic [7:0] MAKE_CODES [NUM_KEYS] = '{
        8'hAA, 8'hF0, 8'hFA, 8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43,
        8'h3B, 8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C,
        8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A, 8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36,
        8'h3D, 8'h3E, 8'h46, 8'h0E, 8'h4E, 8'h55, 8'h5D, 8'h66, 8'h29, 8'h0D, 8'h58, 8'h12,
        8'h14, 8'h11, 8'h59, 8'h5A, 8'h76, 8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83,
        8'h0A, 8'h01, 8'h09, 8'h78, 8'h07, 8'h7E, 8'h54, 8'h5B, 8'h77, 8'h7C, 8'h71, 8'h70,
        8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D, 8'h7B, 8'h79, 8'h4C,
        8'h52, 8'h41, 8'h49, 8'h4A
    };

    typedef struct packed {
        logic             hit;
        logic [KEY_W-1:0] key;
    } lookup_t;

    // Queued work for the back end
    typedef struct packed {
        kind_t      kind;
        logic [7:0] key_index;
        logic [2:0] led_mask;
    } cmd_t;

    // One result item
    typedef struct packed {
        kind_t      kind;
        logic [7:0] key_index;
        logic [7:0] tx_byte;
        logic       last;
    } result_t;

    typedef enum logic {
        BK_HEAD = 1'b0,
        BK_TAIL = 1'b1
    } back_state_t;

    // Match a byte against the make-code table; codes are unique
    function automatic lookup_t lookup(input logic [7:0] code);
        lookup_t res;
        res = '0;
        for (int i = 0; i < NUM_KEYS; i++)
        begin
            if (MAKE_CODES[i] == code)
            begin
                res.hit = 1'b1;
                res.key = KEY_W'(i);
            end
        end
        return res;
    endfunction

endpackage

// File: hdl/ps2kd_if.sv
// Channel interfaces: received byte in, decoded result out.
`timescale 1ns / 1ps

interface ps2kd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] scan_code;

    modport source (output valid, output scan_code, input ready);
    modport sink (input valid, input scan_code, output ready);
endinterface

interface ps2kd_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] key_index;
    logic [7:0] tx_byte;
    logic       last;

    modport source (output valid, output kind, output key_index, output tx_byte,
                    output last, input ready);
    modport sink (input valid, input kind, input key_index, input tx_byte,
                  input last, output ready);
endinterface

// File: hdl/ps2kd_front.sv
// Front end: accept scan bytes, track keyboard state, queue result work.
`timescale 1ns / 1ps

module ps2kd_front
(
    input  logic               clk,
    input  logic               rst_n,
    ps2kd_byte_if.sink         rx,
    output logic               push,
    output ps2kd_pkg::cmd_t    cmd,
    input  logic               full
);

    logic       break_reg, break_next;
    logic       shift_l_reg, shift_l_next;
    logic       shift_r_reg, shift_r_next;
    logic [2:0] lock_reg, lock_next;    // LED mask mirrors the lock bits
    logic [4:0] hold_reg, hold_next;

    logic                accept;
    ps2kd_pkg::lookup_t  hit;
    logic                is_lock;
    logic [2:0]          lock_sel;
    logic [4:0]          hold_sel;
    logic                is_shift;
    logic                shift_right_key;
    logic                shift_cur;
    logic                shift_new;

    assign rx.ready = !full;
    assign accept   = rx.valid && rx.ready;
    assign hit      = ps2kd_pkg::lookup(rx.scan_code);

    // Classify the byte and compute the next keyboard state
    always_comb
    begin
        break_next      = break_reg;
        shift_l_next    = shift_l_reg;
        shift_r_next    = shift_r_reg;
        lock_next       = lock_reg;
        hold_next       = hold_reg;
        push            = 1'b0;
        cmd             = '0;
        is_lock         = 1'b0;
        lock_sel        = '0;
        hold_sel        = '0;
        is_shift        = 1'b0;
        shift_right_key = 1'b0;
        shift_cur       = 1'b0;
        shift_new       = 1'b0;

        if (accept)
        begin
            if (!hit.hit)
            begin
                push     = 1'b1;
                cmd.kind = ps2kd_pkg::KIND_UNKNOWN;
            end
            else
            begin
                break_next = 1'b0;
                unique case (hit.key) inside
                    ps2kd_pkg::KEY_SELFTEST:
                    begin
                        shift_l_next = 1'b0;
                        shift_r_next = 1'b0;
                        lock_next    = '0;
                        hold_next    = '0;
                        push         = 1'b1;
                        cmd.kind     = ps2kd_pkg::KIND_REINIT;
                    end
                    ps2kd_pkg::KEY_BREAK:
                    begin
                        break_next = 1'b1;
                        hold_next  = '0;
                    end
                    ps2kd_pkg::KEY_ACK:
                    begin
                        break_next = break_reg;
                    end
                    ps2kd_pkg::KEY_CAPS:
                    begin
                        is_lock  = 1'b1;
                        lock_sel = ps2kd_pkg::LED_CAPS;
                        hold_sel = ps2kd_pkg::HOLD_CAPS;
                    end
                    ps2kd_pkg::KEY_SCROLL:
                    begin
                        is_lock  = 1'b1;
                        lock_sel = ps2kd_pkg::LED_SCROLL;
                        hold_sel = ps2kd_pkg::HOLD_SCROLL;
                    end
                    ps2kd_pkg::KEY_NUM:
                    begin
                        is_lock  = 1'b1;
                        lock_sel = ps2kd_pkg::LED_NUM;
                        hold_sel = ps2kd_pkg::HOLD_NUM;
                    end
                    ps2kd_pkg::KEY_LSHIFT, ps2kd_pkg::KEY_RSHIFT:
                    begin
                        is_shift        = 1'b1;
                        shift_right_key = (hit.key == ps2kd_pkg::KEY_RSHIFT);
                        hold_sel        = shift_right_key ? ps2kd_pkg::HOLD_RSHIFT
                                                          : ps2kd_pkg::HOLD_LSHIFT;
                    end
                    default:
                    begin
                        // Ordinary key: emit case-adjusted index unless released
                        if (!break_reg)
                        begin
                            push          = 1'b1;
                            cmd.kind      = ps2kd_pkg::KIND_KEY;
                            cmd.key_index = {1'b0, hit.key};
                            if ((shift_l_reg || shift_r_reg) == lock_reg[2])
                                cmd.key_index = {1'b0, hit.key} + ps2kd_pkg::CASE_OFFSET;
                        end
                    end
                endcase

                // Toggle a lock on a fresh press and request an LED update
                if (is_lock && ((hold_reg & hold_sel) == '0) && !break_reg)
                begin
                    lock_next    = lock_reg ^ lock_sel;
                    hold_next    = hold_reg | hold_sel;
                    push         = 1'b1;
                    cmd.kind     = ps2kd_pkg::KIND_TX;
                    cmd.led_mask = lock_reg ^ lock_sel;
                end

                // Shift press sets and holds; a press while set clears
                if (is_shift && ((hold_reg & hold_sel) == '0))
                begin
                    shift_cur = shift_right_key ? shift_r_reg : shift_l_reg;
                    shift_new = !shift_cur;
                    if (!shift_cur)
                        hold_next = hold_reg | hold_sel;
                    if (shift_right_key)
                        shift_r_next = shift_new;
                    else
                        shift_l_next = shift_new;
                end
            end
        end
    end

    // Keyboard state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_reg   <= 1'b0;
            shift_l_reg <= 1'b0;
            shift_r_reg <= 1'b0;
            lock_reg    <= '0;
            hold_reg    <= '0;
        end
        else
        begin
            break_reg   <= break_next;
            shift_l_reg <= shift_l_next;
            shift_r_reg <= shift_r_next;
            lock_reg    <= lock_next;
            hold_reg    <= hold_next;
        end
    end

endmodule

// File: hdl/ps2kd_fifo.sv
// Short command queue between the front and back ends.
`timescale 1ns / 1ps

module ps2kd_fifo #(
    parameter int DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  ps2kd_pkg::cmd_t wdata,
    input  logic            pop,
    output ps2kd_pkg::cmd_t rdata,
    output logic            full,
    output logic            empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ps2kd_pkg::cmd_t  mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign rdata = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wdata;
    end

`include "ps2_scan_code_key_decoder_assert.svh"

    `PS2KD_ASSERT_IMPL(a_fifo_no_overflow, full, !push)
    `PS2KD_ASSERT_IMPL(a_fifo_no_underflow, pop, !empty)
    `PS2KD_ASSERT_IMPL(a_fifo_count_range, 1'b1, count_reg <= CNT_W'(DEPTH))

endmodule

// File: hdl/ps2kd_back.sv
// Back end: expand queued commands into result transactions.
`timescale 1ns / 1ps

module ps2kd_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ps2kd_pkg::cmd_t     entry,
    input  logic                empty,
    output logic                pop,
    ps2kd_result_if.source      res
);

    ps2kd_pkg::back_state_t state_reg, state_next;
    ps2kd_pkg::result_t     res_reg, res_next;
    logic                   res_valid_reg;
    logic [2:0]             mask_reg;
    logic                   load;
    logic                   have_data;
    logic                   tail_state;

    // Output register free or being drained this cycle
    assign load = !res_valid_reg || res.ready;

    assign tail_state = (state_reg == ps2kd_pkg::BK_TAIL);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ps2kd_pkg::BK_HEAD:
            begin
                if (load && !empty && (entry.kind == ps2kd_pkg::KIND_TX))
                    state_next = ps2kd_pkg::BK_TAIL;
            end
            ps2kd_pkg::BK_TAIL:
            begin
                if (load)
                    state_next = ps2kd_pkg::BK_HEAD;
            end
            default: state_next = ps2kd_pkg::BK_HEAD;
        endcase
    end

    // Outputs: pick the next result and pop the queue
    always_comb
    begin
        pop       = 1'b0;
        have_data = 1'b0;
        res_next  = '0;
        unique case (state_reg)
            ps2kd_pkg::BK_HEAD:
            begin
                have_data          = !empty;
                pop                = load && !empty;
                res_next.kind      = entry.kind;
                res_next.key_index = entry.key_index;
                if (entry.kind == ps2kd_pkg::KIND_TX)
                begin
                    res_next.tx_byte = ps2kd_pkg::CODE_LED_CMD;
                    res_next.last    = 1'b0;
                end
                else
                begin
                    res_next.last = 1'b1;
                end
            end
            ps2kd_pkg::BK_TAIL:
            begin
                have_data        = 1'b1;
                res_next.kind    = ps2kd_pkg::KIND_TX;
                res_next.tx_byte = {5'b0, mask_reg};
                res_next.last    = 1'b1;
            end
            default: have_data = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ps2kd_pkg::BK_HEAD;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                res_valid_reg <= have_data;
        end
    end

    // Hold result payload and the pending LED mask
    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_next;
        if (pop)
            mask_reg <= entry.led_mask;
    end

    assign res.valid     = res_valid_reg;
    assign res.kind      = res_reg.kind;
    assign res.key_index = res_reg.key_index;
    assign res.tx_byte   = res_reg.tx_byte;
    assign res.last      = res_reg.last;

`include "ps2_scan_code_key_decoder_assert.svh"

    `PS2KD_ASSERT_IMPL(a_back_tail_has_head, tail_state, res_valid_reg)
    `PS2KD_ASSERT_IMPL(a_back_tail_no_pop, tail_state, !pop)
    `PS2KD_ASSERT_IMPL(a_back_first_half, res_valid_reg && !res_reg.last, tail_state)

endmodule

// File: hdl/ps2_scan_code_key_decoder.sv
// Top level of the PS/2 set-2 scan-code key decoder.
`timescale 1ns / 1ps

// Channel   Dir  Payload                               Transaction
// rx        in   scan_code[7:0]                        rx.valid && rx.ready
// res       out  kind[1:0] key_index tx_byte last      res.valid && res.ready
//
// A taken byte's work is queued, and the back end then registers its result.
// Lock presses give two results (0xED, then the LED mask) in that order.
// Bytes are accepted every cycle while the command queue has room.
// Reset returns all locks, shifts, holds and the break flag to zero.
// A stalled result holds in the output register; the queue absorbs new work.

module ps2_scan_code_key_decoder #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic            clk,
    input  logic            rst_n,
    ps2kd_byte_if.sink      rx,
    ps2kd_result_if.source  res
);

    logic            push;
    logic            pop;
    logic            full;
    logic            empty;
    ps2kd_pkg::cmd_t cmd_in;
    ps2kd_pkg::cmd_t cmd_out;

    ps2kd_front u_front
    (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx),
        .push  (push),
        .cmd   (cmd_in),
        .full  (full)
    );

    ps2kd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_in),
        .pop   (pop),
        .rdata (cmd_out),
        .full  (full),
        .empty (empty)
    );

    ps2kd_back u_back
    (
        .clk   (clk),
        .rst_n (rst_n),
        .entry (cmd_out),
        .empty (empty),
        .pop   (pop),
        .res   (res)
    );

endmodule

// File: tb/sv/tb_ps2_scan_code_key_decoder.sv
// Self-checking testbench for the PS/2 set-2 scan-code key decoder.
`timescale 1ns / 1ps

module tb_ps2_scan_code_key_decoder;

    // Set-2 make codes, position in the table is the key number
    localparam int SET2_KEYS = 88;
    localparam logic [7:0] SET2_MAKE [SET2_KEYS] = '{
        8'hAA, 8'hF0, 8'hFA, 8'h1C, 8'h32, 8'h21, 8'h23, 8'h24, 8'h2B, 8'h34, 8'h33, 8'h43,
        8'h3B, 8'h42, 8'h4B, 8'h3A, 8'h31, 8'h44, 8'h4D, 8'h15, 8'h2D, 8'h1B, 8'h2C, 8'h3C,
        8'h2A, 8'h1D, 8'h22, 8'h35, 8'h1A, 8'h45, 8'h16, 8'h1E, 8'h26, 8'h25, 8'h2E, 8'h36,
        8'h3D, 8'h3E, 8'h46, 8'h0E, 8'h4E, 8'h55, 8'h5D, 8'h66, 8'h29, 8'h0D, 8'h58, 8'h12,
        8'h14, 8'h11, 8'h59, 8'h5A, 8'h76, 8'h05, 8'h06, 8'h04, 8'h0C, 8'h03, 8'h0B, 8'h83,
        8'h0A, 8'h01, 8'h09, 8'h78, 8'h07, 8'h7E, 8'h54, 8'h5B, 8'h77, 8'h7C, 8'h71, 8'h70,
        8'h69, 8'h72, 8'h7A, 8'h6B, 8'h73, 8'h74, 8'h6C, 8'h75, 8'h7D, 8'h7B, 8'h79, 8'h4C,
        8'h52, 8'h41, 8'h49, 8'h4A
    };

    localparam logic [7:0] SC_SELFTEST = 8'hAA;
    localparam logic [7:0] SC_BREAK    = 8'hF0;
    localparam logic [7:0] SC_ACK      = 8'hFA;
    localparam logic [7:0] SC_CAPS     = 8'h58;
    localparam logic [7:0] SC_SCROLL   = 8'h7E;
    localparam logic [7:0] SC_NUM      = 8'h77;
    localparam logic [7:0] SC_LSHIFT   = 8'h12;
    localparam logic [7:0] SC_RSHIFT   = 8'h59;

    localparam int RANDOM_BYTES = 550;

    typedef struct {
        logic [7:0] code;
        bit         drain;
    } rx_item_t;

    logic clk;
    logic rst_n;

    ps2kd_byte_if   rx_if ();
    ps2kd_result_if res_if ();

    ps2_scan_code_key_decoder i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .rx    (rx_if),
        .res   (res_if)
    );

    // Keyboard bytes waiting to be sent and decoder results still owed
    rx_item_t           key_seq_q [$];
    ps2kd_pkg::result_t expected_res_q [$];

    // Shadow decoder state
    logic       brk_armed;
    logic       shl;
    logic       shr;
    logic [2:0] locks;
    logic [4:0] holds;
    logic [2:0] leds;

    int  err_cnt;
    int  byte_cnt;
    logic rx_taken;
    int  tx_gap;
    int  tx_calm;
    int  rd_gap;
    int  rd_calm;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("ps2_scan_code_key_decoder regression: fail");
        $finish;
    end

    function automatic ps2kd_pkg::result_t make_res(ps2kd_pkg::kind_t kind, logic [7:0] idx,
                                                    logic [7:0] tx, logic last);
        ps2kd_pkg::result_t r;
        r.kind      = kind;
        r.key_index = idx;
        r.tx_byte   = tx;
        r.last      = last;
        return r;
    endfunction

    // Random idle length: mostly none, some short, a few long
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    function automatic void clear_decode_state();
        brk_armed = 1'b0;
        shl       = 1'b0;
        shr       = 1'b0;
        locks     = '0;
        holds     = '0;
        leds      = '0;
    endfunction

    // Lock toggle: two transmit bytes unless held or after a break
    function automatic void press_lock(logic [2:0] bit_sel, logic [4:0] hold_sel);
        if ((holds & hold_sel) != '0 || brk_armed)
            return;
        locks = locks ^ bit_sel;
        if ((locks & bit_sel) != '0)
            leds = leds | bit_sel;
        else
            leds = leds & ~bit_sel;
        holds = holds | hold_sel;
        expected_res_q.push_back(make_res(ps2kd_pkg::KIND_TX, 8'd0,
                                          ps2kd_pkg::CODE_LED_CMD, 1'b0));
        expected_res_q.push_back(make_res(ps2kd_pkg::KIND_TX, 8'd0, {5'd0, leds}, 1'b1));
    endfunction

    // Work out what one received byte should produce
    function automatic void decode_expect(logic [7:0] code);
        int         key_no;
        logic       shifted;
        logic       caps_on;
        logic [7:0] idx;
        key_no = -1;
        for (int i = 0; i < SET2_KEYS; i++)
        begin
            if (SET2_MAKE[i] == code)
                key_no = i;
        end
        if (key_no < 0)
        begin
            expected_res_q.push_back(make_res(ps2kd_pkg::KIND_UNKNOWN, 8'd0, 8'd0, 1'b1));
            return;
        end
        if (key_no == int'(ps2kd_pkg::KEY_BREAK))
        begin
            brk_armed = 1'b1;
            holds     = '0;
            return;
        end
        if (key_no == int'(ps2kd_pkg::KEY_ACK))
            return;
        if (key_no == int'(ps2kd_pkg::KEY_SELFTEST))
        begin
            clear_decode_state();
            expected_res_q.push_back(make_res(ps2kd_pkg::KIND_REINIT, 8'd0, 8'd0, 1'b1));
        end
        else if (key_no == int'(ps2kd_pkg::KEY_CAPS))
            press_lock(ps2kd_pkg::LED_CAPS, ps2kd_pkg::HOLD_CAPS);
        else if (key_no == int'(ps2kd_pkg::KEY_SCROLL))
            press_lock(ps2kd_pkg::LED_SCROLL, ps2kd_pkg::HOLD_SCROLL);
        else if (key_no == int'(ps2kd_pkg::KEY_NUM))
            press_lock(ps2kd_pkg::LED_NUM, ps2kd_pkg::HOLD_NUM);
        else if (key_no == int'(ps2kd_pkg::KEY_LSHIFT))
        begin
            if ((holds & ps2kd_pkg::HOLD_LSHIFT) == '0)
            begin
                if (!shl)
                    holds = holds | ps2kd_pkg::HOLD_LSHIFT;
                shl = ~shl;
            end
        end
        else if (key_no == int'(ps2kd_pkg::KEY_RSHIFT))
        begin
            if ((holds & ps2kd_pkg::HOLD_RSHIFT) == '0)
            begin
                if (!shr)
                    holds = holds | ps2kd_pkg::HOLD_RSHIFT;
                shr = ~shr;
            end
        end
        else if (!brk_armed)
        begin
            shifted = shl | shr;
            caps_on = (locks & ps2kd_pkg::LED_CAPS) != '0;
            idx = 8'(key_no);
            if (shifted == caps_on)
                idx = idx + ps2kd_pkg::CASE_OFFSET;
            expected_res_q.push_back(make_res(ps2kd_pkg::KIND_KEY, idx, 8'd0, 1'b1));
        end
        brk_armed = 1'b0;
    endfunction

    // Check results, then predict from the byte taken at this edge
    always @(posedge clk)
    begin
        ps2kd_pkg::result_t want;
        if (rst_n)
        begin
            if (res_if.valid && res_if.ready)
            begin
                if (expected_res_q.size() == 0)
                begin
                    $error("unexpected result: kind %0d key_index %0d tx_byte %0h last %0b",
                           res_if.kind, res_if.key_index, res_if.tx_byte, res_if.last);
                    err_cnt++;
                end
                else
                begin
                    want = expected_res_q.pop_front();
                    if (res_if.kind !== want.kind)
                    begin
                        $error("kind: expected %0d, got %0d", want.kind, res_if.kind);
                        err_cnt++;
                    end
                    if (res_if.key_index !== want.key_index)
                    begin
                        $error("key_index: expected %0d, got %0d", want.key_index,
                               res_if.key_index);
                        err_cnt++;
                    end
                    if (res_if.tx_byte !== want.tx_byte)
                    begin
                        $error("tx_byte: expected %0h, got %0h", want.tx_byte,
                               res_if.tx_byte);
                        err_cnt++;
                    end
                    if (res_if.last !== want.last)
                    begin
                        $error("last: expected %0b, got %0b", want.last, res_if.last);
                        err_cnt++;
                    end
                end
            end
            if (rx_if.valid && rx_if.ready)
                decode_expect(rx_if.scan_code);
        end
        rx_taken <= rx_if.valid && rx_if.ready;
    end

    // Byte driver: hold until taken, then idle or present the next byte
    always @(negedge clk)
    begin
        rx_item_t item;
        if (rst_n && (!rx_if.valid || rx_taken))
        begin
            if (tx_gap > 0)
            begin
                rx_if.valid <= 1'b0;
                tx_gap--;
            end
            else if (key_seq_q.size() == 0 ||
                     (key_seq_q[0].drain && expected_res_q.size() != 0))
            begin
                rx_if.valid <= 1'b0;
            end
            else
            begin
                item = key_seq_q.pop_front();
                rx_if.scan_code <= item.code;
                rx_if.valid     <= 1'b1;
                if (tx_calm > 0)
                    tx_calm--;
                else if ($urandom_range(0, 39) == 0)
                    tx_calm = $urandom_range(20, 60);
                else
                    tx_gap = draw_gap();
            end
        end
    end

    // Result sink: random back-pressure with calm stretches
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rd_gap > 0)
            begin
                res_if.ready <= 1'b0;
                rd_gap--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (rd_calm > 0)
                    rd_calm--;
                else if ($urandom_range(0, 39) == 0)
                    rd_calm = $urandom_range(20, 60);
                else
                    rd_gap = draw_gap();
            end
        end
    end

    task automatic add_byte(logic [7:0] code, bit drain = 1'b0);
        rx_item_t item;
        item.code  = code;
        item.drain = drain;
        key_seq_q.push_back(item);
        if (code != SC_ACK)
            byte_cnt++;
    endtask

    // Press with typematic repeats, then release
    task automatic add_stroke(logic [7:0] code);
        int reps;
        reps = $urandom_range(0, 3) == 0 ? $urandom_range(1, 2) : 0;
        add_byte(code);
        for (int i = 0; i < reps; i++)
            add_byte(code);
        add_byte(SC_BREAK);
        add_byte(code);
    endtask

    function automatic logic [7:0] plain_key();
        int k;
        do
            k = $urandom_range(3, SET2_KEYS - 1);
        while (k == int'(ps2kd_pkg::KEY_CAPS) || k == int'(ps2kd_pkg::KEY_SCROLL) ||
               k == int'(ps2kd_pkg::KEY_NUM) || k == int'(ps2kd_pkg::KEY_LSHIFT) ||
               k == int'(ps2kd_pkg::KEY_RSHIFT));
        return SET2_MAKE[k];
    endfunction

    // Stimulus
    initial
    begin
        int         sel;
        int         n;
        logic [7:0] lock_code;
        logic [7:0] shift_code;
        rst_n           = 1'b0;
        rx_if.valid     = 1'b0;
        rx_if.scan_code = 8'd0;
        res_if.ready    = 1'b0;
        rx_taken        = 1'b0;
        err_cnt         = 0;
        byte_cnt        = 0;
        tx_gap          = 0;
        tx_calm         = 0;
        rd_gap          = 0;
        rd_calm         = 0;
        clear_decode_state();

        // Directed: field extremes, unknown bytes, every key action
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(SET2_MAKE[3]);
        add_byte(SET2_MAKE[SET2_KEYS - 1]);
        add_byte(SC_ACK);
        add_byte(SC_CAPS);
        add_byte(SC_CAPS);
        add_byte(SET2_MAKE[3]);
        add_byte(SC_LSHIFT);
        add_byte(SC_LSHIFT);
        add_byte(SET2_MAKE[4]);
        add_byte(SC_BREAK);
        add_byte(SET2_MAKE[4]);
        add_byte(SC_BREAK);
        add_byte(SC_LSHIFT);
        add_byte(SC_BREAK);
        add_byte(SC_CAPS);
        add_byte(SC_BREAK);
        add_byte(8'h80);
        add_byte(SC_SCROLL);
        add_byte(SC_NUM);
        add_byte(SC_RSHIFT);
        add_byte(SC_CAPS);
        add_byte(SET2_MAKE[59]);
        add_byte(SC_SELFTEST, 1'b1);

        // Random: mostly well-formed key traffic, some noise and broken sequences
        while (byte_cnt < RANDOM_BYTES)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 40)
                add_stroke(plain_key());
            else if (sel < 55)
            begin
                shift_code = $urandom_range(0, 1) ? SC_LSHIFT : SC_RSHIFT;
                add_byte(shift_code);
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++)
                    add_stroke(plain_key());
                add_byte(SC_BREAK);
                add_byte(shift_code);
            end
            else if (sel < 70)
            begin
                case ($urandom_range(0, 2))
                    0: lock_code = SC_CAPS;
                    1: lock_code = SC_SCROLL;
                    default: lock_code = SC_NUM;
                endcase
                add_stroke(lock_code);
            end
            else if (sel < 80)
                add_byte(8'($urandom_range(0, 255)));
            else if (sel < 85)
            begin
                add_byte(SC_BREAK);
                if ($urandom_range(0, 1))
                    add_byte(SC_BREAK);
                else
                    add_byte(SET2_MAKE[$urandom_range(3, SET2_KEYS - 1)]);
            end
            else if (sel < 88)
                add_byte(SC_ACK);
            else if (sel < 90)
                add_byte(SC_SELFTEST, $urandom_range(0, 3) == 0);
            else
                add_byte(SET2_MAKE[$urandom_range(0, SET2_KEYS - 1)]);
        end

        // Release reset
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Drain stimulus, then the results still owed
        while (key_seq_q.size() != 0 || rx_if.valid)
            @(negedge clk);
        while (expected_res_q.size() != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);

        if (err_cnt == 0 && expected_res_q.size() == 0)
            $display("ps2_scan_code_key_decoder regression: pass");
        else
            $display("ps2_scan_code_key_decoder regression: fail");
        $finish;
    end

endmodule

// File: ps2_scan_code_key_decoder.f
+incdir+hdl
hdl/ps2kd_pkg.sv
hdl/ps2kd_if.sv
hdl/ps2kd_front.sv
hdl/ps2kd_fifo.sv
hdl/ps2kd_back.sv
hdl/ps2_scan_code_key_decoder.sv
tb/sv/tb_ps2_scan_code_key_decoder.sv
